[hw/rtl/oledfb_pkg.sv]
`default_nettype none

package oledfb_pkg;

  // Default geometry of the display
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Field widths fixed by the largest legal geometry
  localparam int COL_W      = 7;
  localparam int PAGE_W     = 3;
  localparam int BYTE_CNT_W = 8;

  // Init command list
  localparam int INIT_LEN   = 27;
  localparam int INIT_IDX_W = 5;

  // Refresh page header bytes
  localparam logic [7:0] REF_PAGE_BASE = 8'hb0;
  localparam logic [7:0] REF_COL_LO    = 8'h01;
  localparam logic [7:0] REF_COL_HI    = 8'h10;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CMD_DRAW    = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_REFRESH = 3'd2,
    CMD_INIT    = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_t;

  // One classified item as it travels from front to back
  typedef struct packed {
    cmd_t              op;
    logic [COL_W-1:0]  col;
    logic [PAGE_W-1:0] page;
    logic [2:0]        bit_idx;
    logic              pixel_on;
    logic [7:0]        value;
  } op_item_t;

  // Fixed panel start-up command list
  function automatic logic [7:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'hae;
      5'd1:    b = 8'h00;
      5'd2:    b = 8'h10;
      5'd3:    b = 8'h40;
      5'd4:    b = 8'h81;
      5'd5:    b = 8'hcf;
      5'd6:    b = 8'ha1;
      5'd7:    b = 8'hc8;
      5'd8:    b = 8'ha6;
      5'd9:    b = 8'ha8;
      5'd10:   b = 8'h3f;
      5'd11:   b = 8'hd3;
      5'd12:   b = 8'h00;
      5'd13:   b = 8'hd5;
      5'd14:   b = 8'h80;
      5'd15:   b = 8'hd9;
      5'd16:   b = 8'hf1;
      5'd17:   b = 8'hda;
      5'd18:   b = 8'h12;
      5'd19:   b = 8'h40;
      5'd20:   b = 8'h20;
      5'd21:   b = 8'h02;
      5'd22:   b = 8'h8d;
      5'd23:   b = 8'h14;
      5'd24:   b = 8'ha4;
      5'd25:   b = 8'ha6;
      5'd26:   b = 8'haf;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/oledfb_front.sv]
`default_nettype none

module oledfb_front #(
  parameter int COLUMNS = oledfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = oledfb_pkg::PAGES_DEF
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_cmd,
  input  logic [7:0]           in_x_coord,
  input  logic [7:0]           in_y_coord,
  input  logic                 in_pixel_on,
  input  logic [7:0]           in_fill_value,
  input  logic                 busy_clear,
  input  logic                 q_full,
  output logic                 q_push,
  output oledfb_pkg::op_item_t q_item
);
  import oledfb_pkg::*;

  logic in_range;
  logic keep;

  // Check the point against the panel size
  assign in_range = ({1'b0, in_x_coord} < 9'(COLUMNS)) &&
                    ({1'b0, in_y_coord} < 9'(8 * PAGES));

  // Drop unused codes and points off the panel
  always_comb begin
    unique case (in_cmd) inside
      CMD_DRAW:                                  keep = in_range;
      CMD_FILL, CMD_REFRESH, CMD_INIT, CMD_TICK: keep = 1'b1;
      default:                                   keep = 1'b0;
    endcase
  end

  // Hold the input while the queue is full or the store is being swept
  assign in_stall = q_full | busy_clear;
  assign q_push   = in_valid & ~in_stall & keep;

  // Map the point to column, page and bit
  always_comb begin
    q_item.op       = cmd_t'(in_cmd);
    q_item.col      = in_x_coord[COL_W-1:0];
    q_item.page     = PAGE_W'(PAGES - 1) - in_y_coord[5:3];
    q_item.bit_idx  = in_y_coord[2:0];
    q_item.pixel_on = in_pixel_on;
    q_item.value    = in_fill_value;
  end

endmodule

`default_nettype wire

[hw/rtl/oledfb_queue.sv]
`default_nettype none

module oledfb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  oledfb_pkg::op_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output oledfb_pkg::op_item_t pop_item
);
  import oledfb_pkg::*;

  op_item_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/oledfb_back.sv]
`default_nettype none

module oledfb_back #(
  parameter int COLUMNS = oledfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = oledfb_pkg::PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  oledfb_pkg::op_item_t q_item,
  output logic                 q_pop,
  output logic                 busy_clear,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_serial_bit,
  output logic                 out_is_data,
  output logic                 out_byte_end,
  output logic                 out_sequence_done
);
  import oledfb_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DRAW  = 4'b0100,
    ST_TICK  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_REFRESH = 3'b010,
    MODE_INIT    = 3'b100
  } mode_t;

  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [PAGE_W-1:0]     page_cnt_r, page_cnt_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]            bit_cnt_r, bit_cnt_nxt;
  logic [AW-1:0]         sweep_addr_r, sweep_addr_nxt;
  logic [7:0]            sweep_val_r, sweep_val_nxt;
  logic [AW-1:0]         draw_addr_r, draw_addr_nxt;
  logic [2:0]            draw_bit_r, draw_bit_nxt;
  logic                  draw_on_r, draw_on_nxt;

  logic [7:0]            store_mem [DEPTH];
  logic [7:0]            rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [7:0]            wr_data;

  logic                  out_valid_r;
  logic                  out_bit_r, out_data_r, out_end_r, out_done_r;

  logic [7:0]            cmd_byte;
  logic                  seq_is_data;
  logic                  last_byte;
  logic                  last_page;
  logic [COL_W-1:0]      data_col;
  logic [AW-1:0]         data_addr;
  logic [AW-1:0]         item_addr;
  logic [7:0]            cur_byte;
  logic                  tick_bit, tick_end, tick_done;
  logic                  out_free;
  logic                  emit;

  mode_t                 mode_adv;
  logic [PAGE_W-1:0]     page_adv;
  logic [BYTE_CNT_W-1:0] byte_adv;
  logic [2:0]            bit_adv;

  // Frame store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= store_mem[rd_addr];
  end

  // Byte the sequencer sends next when it is a command byte
  always_comb begin
    cmd_byte    = 8'h00;
    seq_is_data = 1'b0;
    last_byte   = 1'b0;
    last_page   = 1'b0;
    unique case (mode_r)
      MODE_INIT: begin
        cmd_byte  = init_byte(byte_cnt_r[INIT_IDX_W-1:0]);
        last_byte = (byte_cnt_r == BYTE_CNT_W'(INIT_LEN - 1));
        last_page = 1'b1;
      end
      MODE_REFRESH: begin
        if (byte_cnt_r == BYTE_CNT_W'(0)) begin
          cmd_byte = REF_PAGE_BASE + 8'(page_cnt_r);
        end else if (byte_cnt_r == BYTE_CNT_W'(1)) begin
          cmd_byte = REF_COL_LO;
        end else if (byte_cnt_r == BYTE_CNT_W'(2)) begin
          cmd_byte = REF_COL_HI;
        end else begin
          seq_is_data = 1'b1;
        end
        last_byte = (byte_cnt_r == BYTE_CNT_W'(COLUMNS + 2));
        last_page = (page_cnt_r == PAGE_W'(PAGES - 1));
      end
      default: ;
    endcase
  end

  // Store addresses for the data byte and for a draw
  assign data_col  = COL_W'(byte_cnt_r - BYTE_CNT_W'(3));
  assign data_addr = AW'(32'(data_col) * 32'(PAGES) + 32'(page_cnt_r));
  assign item_addr = AW'(32'(q_item.col) * 32'(PAGES) + 32'(q_item.page));

  // Pick the current bit, MSB first
  assign cur_byte  = (state_r == ST_TICK) ? rd_data_r : cmd_byte;
  assign tick_bit  = cur_byte[~bit_cnt_r];
  assign tick_end  = (bit_cnt_r == 3'd7);
  assign tick_done = last_byte & last_page & tick_end;

  // Counter values after a bit goes out
  always_comb begin
    mode_adv = mode_r;
    page_adv = page_cnt_r;
    byte_adv = byte_cnt_r;
    bit_adv  = bit_cnt_r;
    if (!tick_end) begin
      bit_adv = bit_cnt_r + 3'd1;
    end else if (tick_done) begin
      mode_adv = MODE_IDLE;
      page_adv = '0;
      byte_adv = '0;
      bit_adv  = '0;
    end else begin
      bit_adv = '0;
      if (mode_r == MODE_REFRESH && last_byte) begin
        byte_adv = '0;
        page_adv = page_cnt_r + 1'b1;
      end else begin
        byte_adv = byte_cnt_r + 1'b1;
      end
    end
  end

  assign out_free = ~out_valid_r | ~out_stall;

  // Execute queued items
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    page_cnt_nxt   = page_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_val_nxt  = sweep_val_r;
    draw_addr_nxt  = draw_addr_r;
    draw_bit_nxt   = draw_bit_r;
    draw_on_nxt    = draw_on_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = data_addr;
    wr_en          = 1'b0;
    wr_addr        = sweep_addr_r;
    wr_data        = sweep_val_r;
    emit           = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        wr_en = 1'b1;
        if (sweep_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op) inside
            CMD_DRAW: begin
              rd_en         = 1'b1;
              rd_addr       = item_addr;
              draw_addr_nxt = item_addr;
              draw_bit_nxt  = q_item.bit_idx;
              draw_on_nxt   = q_item.pixel_on;
              q_pop         = 1'b1;
              state_nxt     = ST_DRAW;
            end
            CMD_FILL: begin
              sweep_val_nxt  = q_item.value;
              sweep_addr_nxt = '0;
              q_pop          = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            CMD_REFRESH, CMD_INIT: begin
              mode_nxt     = (q_item.op == CMD_REFRESH) ? MODE_REFRESH : MODE_INIT;
              page_cnt_nxt = '0;
              byte_cnt_nxt = '0;
              bit_cnt_nxt  = '0;
              q_pop        = 1'b1;
            end
            CMD_TICK: begin
              if (mode_r == MODE_IDLE) begin
                q_pop = 1'b1;
              end else if (seq_is_data) begin
                rd_en     = 1'b1;
                q_pop     = 1'b1;
                state_nxt = ST_TICK;
              end else if (out_free) begin
                emit         = 1'b1;
                mode_nxt     = mode_adv;
                page_cnt_nxt = page_adv;
                byte_cnt_nxt = byte_adv;
                bit_cnt_nxt  = bit_adv;
                q_pop        = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_DRAW: begin
        wr_en                = 1'b1;
        wr_addr              = draw_addr_r;
        wr_data              = rd_data_r;
        wr_data[~draw_bit_r] = draw_on_r;
        state_nxt            = ST_IDLE;
      end
      ST_TICK: begin
        if (out_free) begin
          emit         = 1'b1;
          mode_nxt     = mode_adv;
          page_cnt_nxt = page_adv;
          byte_cnt_nxt = byte_adv;
          bit_cnt_nxt  = bit_adv;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      mode_r       <= MODE_IDLE;
      page_cnt_r   <= '0;
      byte_cnt_r   <= '0;
      bit_cnt_r    <= '0;
      sweep_addr_r <= '0;
      sweep_val_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      page_cnt_r   <= page_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_val_r  <= sweep_val_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Draw operands and result payload
  always_ff @(posedge clk) begin
    draw_addr_r <= draw_addr_nxt;
    draw_bit_r  <= draw_bit_nxt;
    draw_on_r   <= draw_on_nxt;
    if (emit) begin
      out_bit_r  <= tick_bit;
      out_data_r <= seq_is_data;
      out_end_r  <= tick_end;
      out_done_r <= tick_done;
    end
  end

  assign busy_clear        = (state_r == ST_SWEEP);
  assign out_valid         = out_valid_r;
  assign out_serial_bit    = out_bit_r;
  assign out_is_data       = out_data_r;
  assign out_byte_end      = out_end_r;
  assign out_sequence_done = out_done_r;

endmodule

`default_nettype wire

[hw/rtl/oled_frame_buffer_serial_refresh.sv]
// Monochrome OLED frame store with a serial refresh engine.
// Input channel (in_valid / in_stall): each item carries a command. Draw sets or
// clears one pixel, fill writes one byte everywhere, the two start commands arm
// the init list or a full-screen refresh, and a tick shifts out one bit.
// Result channel (out_valid / out_stall): one item per tick while a sequence
// runs, giving the bit, the data/command flag, end of byte and end of sequence.
// Items pass a two-entry queue from the decoder to the execution engine.
// A command-byte tick reaches the output through the queue and the output
// register; a data-byte tick also waits for a registered read of the frame store.
// Starts and command-byte ticks are done from the idle state; a draw reads then
// writes the store and a data-byte tick reads then sends, and the engine takes
// no new item until it is back in idle; a fill sweeps the whole store.
// Reset: synchronous, active low. After it the store is cleared by a sweep over
// all COLUMNS*PAGES bytes (1024 by default), during which in_stall is held high.
// Receiver stall: the result stays in the output register; the engine stops at
// the next tick that would need it, and the queue then fills and holds the input.
`default_nettype none

module oled_frame_buffer_serial_refresh #(
  parameter int COLUMNS = oledfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = oledfb_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_x_coord,
  input  logic [7:0] in_y_coord,
  input  logic       in_pixel_on,
  input  logic [7:0] in_fill_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_bit,
  output logic       out_is_data,
  output logic       out_byte_end,
  output logic       out_sequence_done
);
  import oledfb_pkg::*;

  logic     busy_clear;
  logic     q_full;
  logic     q_push;
  logic     q_valid;
  logic     q_pop;
  op_item_t push_item;
  op_item_t pop_item;

  // Decode and filter incoming items
  oledfb_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_pixel_on   (in_pixel_on),
    .in_fill_value (in_fill_value),
    .busy_clear    (busy_clear),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // Decouple decoder from engine
  oledfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  // Frame store, sequencer and output register
  oledfb_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .busy_clear        (busy_clear),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_serial_bit    (out_serial_bit),
    .out_is_data       (out_is_data),
    .out_byte_end      (out_byte_end),
    .out_sequence_done (out_sequence_done)
  );

  // The last bit of a sequence is always the last bit of a byte
  a_done_at_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sequence_done |-> out_byte_end)
    else $error("sequence_done without byte_end");

  // The engine never takes from an empty queue
  a_pop_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Input is held as the clearing sweep starts after a reset
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing sweep");

endmodule

`default_nettype wire

[tb/tb_oled_frame_buffer_serial_refresh.sv]
module tb_oled_frame_buffer_serial_refresh;
  timeunit 1ns;
  timeprecision 1ps;

  import oledfb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1000;
  localparam int REFRESH_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int START_PERMILLE = 5;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_REFRESH,
    SEQ_INIT
  } seq_mode_t;

  // One serial clock pulse as it leaves the block
  typedef struct packed {
    logic serial_bit;
    logic is_data;
    logic byte_end;
    logic sequence_done;
  } serial_beat_t;

  // Frame store mirror, shift engine mirror and the beats still to arrive
  class refresh_scoreboard;
    localparam int NCOLS  = COLUMNS_DEF;
    localparam int NPAGES = PAGES_DEF;

    logic [7:0]   frame [NCOLS*NPAGES];
    logic [7:0]   init_seq [INIT_LEN];
    seq_mode_t    mode;
    logic [2:0]   page_cnt;
    logic [7:0]   byte_cnt;
    logic [2:0]   bit_cnt;
    serial_beat_t beats_due [$];
    int mismatches;
    int n_ticks, n_draws, n_fills, n_starts, n_other, n_beats;
    int inits_done, refreshes_done;

    function new();
      init_seq = '{8'hae, 8'h00, 8'h10, 8'h40, 8'h81, 8'hcf, 8'ha1, 8'hc8, 8'ha6,
                   8'ha8, 8'h3f, 8'hd3, 8'h00, 8'hd5, 8'h80, 8'hd9, 8'hf1, 8'hda,
                   8'h12, 8'h40, 8'h20, 8'h02, 8'h8d, 8'h14, 8'ha4, 8'ha6, 8'haf};
      foreach (frame[i]) frame[i] = 8'h00;
      mode = SEQ_IDLE;
      clear_counters();
      mismatches = 0;
      n_ticks = 0; n_draws = 0; n_fills = 0; n_starts = 0; n_other = 0;
      n_beats = 0; inits_done = 0; refreshes_done = 0;
    endfunction

    function void clear_counters();
      page_cnt = '0;
      byte_cnt = '0;
      bit_cnt  = '0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 20) $display("mismatch: %s", what);
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    // Work out the beat of one tick and advance the counters
    function void shift_tick();
      logic [7:0]   cur;
      logic         last_byte, last_all;
      serial_beat_t beat;
      cur = 8'h00;
      beat = '0;
      last_byte = 1'b0;
      last_all = 1'b0;
      if (mode == SEQ_IDLE) return;
      if (mode == SEQ_INIT) begin
        cur = init_seq[byte_cnt];
        last_byte = (byte_cnt == INIT_LEN - 1);
        last_all = last_byte;
      end else begin
        if (byte_cnt == 0) cur = REF_PAGE_BASE + 8'(page_cnt);
        else if (byte_cnt == 1) cur = REF_COL_LO;
        else if (byte_cnt == 2) cur = REF_COL_HI;
        else begin
          beat.is_data = 1'b1;
          cur = frame[(int'(byte_cnt) - 3) * NPAGES + int'(page_cnt)];
        end
        last_byte = (byte_cnt == NCOLS + 2);
        last_all = last_byte && (page_cnt == NPAGES - 1);
      end
      beat.serial_bit = cur[7 - bit_cnt];
      beat.byte_end = (bit_cnt == 3'd7);
      beat.sequence_done = last_all && beat.byte_end;
      beats_due.push_back(beat);

      // advance bit, then byte, then page; drop to idle after the last bit
      if (!beat.byte_end) begin
        bit_cnt = bit_cnt + 3'd1;
      end else if (beat.sequence_done) begin
        if (mode == SEQ_INIT) inits_done++;
        else refreshes_done++;
        mode = SEQ_IDLE;
        clear_counters();
      end else begin
        bit_cnt = '0;
        if (mode == SEQ_REFRESH && last_byte) begin
          byte_cnt = '0;
          page_cnt = page_cnt + 3'd1;
        end else begin
          byte_cnt = byte_cnt + 8'd1;
        end
      end
    endfunction

    // Apply one accepted item to the mirror
    function void note_input(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                             logic on, logic [7:0] fill);
      int col, row, idx;
      logic [7:0] mask;
      col = int'(x);
      row = int'(y);
      case (cmd_t'(cmd))
        CMD_DRAW: begin
          n_draws++;
          if (col < NCOLS && row < 8 * NPAGES) begin
            idx = col * NPAGES + (NPAGES - 1 - row / 8);
            mask = 8'h80 >> (row % 8);
            if (on) frame[idx] = frame[idx] | mask;
            else frame[idx] = frame[idx] & ~mask;
          end
        end
        CMD_FILL: begin
          n_fills++;
          foreach (frame[i]) frame[i] = fill;
        end
        CMD_REFRESH: begin
          n_starts++;
          mode = SEQ_REFRESH;
          clear_counters();
        end
        CMD_INIT: begin
          n_starts++;
          mode = SEQ_INIT;
          clear_counters();
        end
        CMD_TICK: begin
          n_ticks++;
          shift_tick();
        end
        default: n_other++;
      endcase
    endfunction

    // Compare one accepted beat with the oldest one due
    function void check_result(serial_beat_t got);
      serial_beat_t want;
      n_beats++;
      if (beats_due.size() == 0) begin
        report($sformatf("beat %0d arrived with none due", n_beats));
        return;
      end
      want = beats_due.pop_front();
      if (got.serial_bit !== want.serial_bit)
        report($sformatf("beat %0d serial_bit %b, want %b", n_beats,
                         got.serial_bit, want.serial_bit));
      if (got.is_data !== want.is_data)
        report($sformatf("beat %0d is_data %b, want %b", n_beats,
                         got.is_data, want.is_data));
      if (got.byte_end !== want.byte_end)
        report($sformatf("beat %0d byte_end %b, want %b", n_beats,
                         got.byte_end, want.byte_end));
      if (got.sequence_done !== want.sequence_done)
        report($sformatf("beat %0d sequence_done %b, want %b", n_beats,
                         got.sequence_done, want.sequence_done));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_cmd;
  logic [7:0] in_x_coord;
  logic [7:0] in_y_coord;
  logic       in_pixel_on;
  logic [7:0] in_fill_value;
  logic       out_valid;
  logic       out_stall;
  logic       out_serial_bit;
  logic       out_is_data;
  logic       out_byte_end;
  logic       out_sequence_done;

  refresh_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  oled_frame_buffer_serial_refresh dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_pixel_on      (in_pixel_on),
    .in_fill_value    (in_fill_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_serial_bit   (out_serial_bit),
    .out_is_data      (out_is_data),
    .out_byte_end     (out_byte_end),
    .out_sequence_done(out_sequence_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Take beats and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(serial_beat_t'({out_serial_bit, out_is_data, out_byte_end,
                                      out_sequence_done}));
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item, idling first at random, and hold it until taken
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] x,
                           input logic [7:0] y, input logic on,
                           input logic [7:0] fill);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_pixel_on   <= on;
    in_fill_value <= fill;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, x, y, on, fill);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Mostly ticks, some draws, rare fills and starts, a little noise
  task automatic send_random_item();
    logic [2:0] cmd;
    logic [7:0] x, y, fill;
    logic on;
    int r;
    x = 8'($urandom);
    y = 8'($urandom);
    on = 1'($urandom);
    fill = 8'($urandom);
    r = $urandom_range(999);
    if (r < 8) cmd = CMD_FILL;
    else if (r < 8 + START_PERMILLE) cmd = CMD_REFRESH;
    else if (r < 8 + 2 * START_PERMILLE) cmd = CMD_INIT;
    else if (r < 28 + 2 * START_PERMILLE) cmd = 3'($urandom_range(7, 5));
    else if (r < 228 + 2 * START_PERMILLE) begin
      cmd = CMD_DRAW;
      if ($urandom_range(99) < 85) x = 8'($urandom_range(127));
      if ($urandom_range(99) < 85) y = 8'($urandom_range(63));
    end else begin
      cmd = CMD_TICK;
    end
    send_item(cmd, x, y, on, fill);
  endtask

  initial begin
    int idle_pct [4];
    int stall_pct [4];
    sb = new();
    idle_pct  = '{0, 67, 0, 23};
    stall_pct = '{0, 0, 67, 23};
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_TICK;
    in_x_coord    <= 8'h00;
    in_y_coord    <= 8'h00;
    in_pixel_on   <= 1'b0;
    in_fill_value <= 8'h00;
    out_stall     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, unused codes, corner pixels, ignored points, restarts
    send_item(CMD_TICK, 8'h00, 8'h00, 1'b0, 8'h00);
    send_item(3'd5, 8'hff, 8'hff, 1'b1, 8'hff);
    send_item(3'd7, 8'h00, 8'h00, 1'b0, 8'h00);
    send_item(CMD_FILL, 8'h00, 8'h00, 1'b0, 8'hff);
    send_item(CMD_DRAW, 8'd0, 8'd0, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd127, 8'd63, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd0, 8'd63, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd127, 8'd0, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd128, 8'd5, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd5, 8'd64, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd255, 8'd255, 1'b0, 8'h00);
    send_item(CMD_DRAW, 8'd127, 8'd63, 1'b1, 8'h00);
    send_item(CMD_INIT, 8'h00, 8'h00, 1'b0, 8'h00);
    repeat (3) send_tick();
    send_item(CMD_INIT, 8'h00, 8'h00, 1'b0, 8'h00);
    repeat (2) send_tick();
    send_item(CMD_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00);
    send_item(CMD_FILL, 8'h00, 8'h00, 1'b0, 8'h00);
    repeat (2) send_tick();

    // Random items over the four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random_item();
    end

    // Scatter pixels and send the page header and first columns of a refresh
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_item(CMD_FILL, 8'h00, 8'h00, 1'b0, 8'($urandom));
    repeat (20)
      send_item(CMD_DRAW, 8'($urandom_range(127)), 8'($urandom_range(63)),
                1'($urandom), 8'($urandom));
    send_item(CMD_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00);
    repeat (REFRESH_ITEMS) begin
      if ($urandom_range(99) < 3)
        send_item(CMD_DRAW, 8'($urandom_range(127)), 8'($urandom_range(63)),
                  1'($urandom), 8'($urandom));
      else
        send_tick();
    end

    // Run the init list through to its last bit
    send_item(CMD_INIT, 8'h00, 8'h00, 1'b0, 8'h00);
    while (sb.mode != SEQ_IDLE) send_tick();
    repeat (3) send_tick();

    // Drain
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));

    $display("items: %0d ticks, %0d draws, %0d fills, %0d starts, %0d ignored codes",
             sb.n_ticks, sb.n_draws, sb.n_fills, sb.n_starts, sb.n_other);
    $display("beats checked: %0d; sequences completed: %0d init, %0d refresh",
             sb.n_beats, sb.inits_done, sb.refreshes_done);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/oledfb_pkg.sv
hw/rtl/oledfb_front.sv
hw/rtl/oledfb_queue.sv
hw/rtl/oledfb_back.sv
hw/rtl/oled_frame_buffer_serial_refresh.sv
tb/tb_oled_frame_buffer_serial_refresh.sv
